@@ sv/psmd_pkg.sv @@
// Package for the power status median debounce unit.
// Sizes, reset values, register indexes and the insertion control struct.
// No dependencies.
package psmd_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int ROUND_SAMPLES = 20;
    localparam int RANK_INDEX    = 10;
    localparam int WINDOW_DEPTH  = 70;

    localparam int RANK_SEL = (RANK_INDEX >= ROUND_SAMPLES) ? ROUND_SAMPLES - 1 : RANK_INDEX;
    localparam int CNT_W    = (ROUND_SAMPLES > 1) ? $clog2(ROUND_SAMPLES) : 1;
    localparam int RUN_W    = $clog2(WINDOW_DEPTH + 1);

    localparam logic [SAMPLE_W-1:0] MAIN_THR_RST = SAMPLE_W'(2854);
    localparam logic [SAMPLE_W-1:0] BAT_THR_RST  = SAMPLE_W'(2730);

    typedef enum logic {
        CFG_MAIN_THR = 1'b0,
        CFG_BAT_THR  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic insert;   // an item is taken this cycle
        logic fresh;    // first item of a round, older contents are discarded
    } t_ins_ctl;

endpackage

@@ sv/psmd_sort_cell.sv @@
// One cell of the insertion sort chain: holds one sample of the round.
// Depends on psmd_pkg.
module psmd_sort_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psmd_pkg::t_ins_ctl            i_ctl,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_left_gt,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic                          i_left_valid,
    output logic                          o_gt,
    output logic [psmd_pkg::SAMPLE_W-1:0] o_val,
    output logic                          o_valid
);

    logic [psmd_pkg::SAMPLE_W-1:0] r_val;
    logic [psmd_pkg::SAMPLE_W-1:0] n_val;
    logic                          r_valid;

    // empty or discarded cells count as larger than anything
    assign o_gt    = i_ctl.fresh || !r_valid || (r_val > i_sample);
    assign o_val   = r_val;
    assign o_valid = r_valid;

    always_comb begin
        n_val = r_val;
        if (o_gt) begin
            n_val = i_left_gt ? i_left_val : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert) begin
            r_valid <= i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_val <= n_val;
        end
    end

endmodule

@@ sv/psmd_rank_chain.sv @@
// Row of sort cells for one channel; gives the ranked sample of the round.
// Depends on psmd_pkg and psmd_sort_cell.
module psmd_rank_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psmd_pkg::t_ins_ctl            i_ctl,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_sample,
    output logic [psmd_pkg::SAMPLE_W-1:0] o_rank,
    output logic                          o_full
);

    localparam int N = psmd_pkg::ROUND_SAMPLES;

    logic [N-1:0]                          w_gt;
    logic [N-1:0]                          w_valid;
    logic [N-1:0]                          w_left_valid;
    logic [N-1:0][psmd_pkg::SAMPLE_W-1:0]  w_val;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left_valid[g] = 1'b1;
            psmd_sort_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_sample     (i_sample),
                .i_left_gt    (1'b0),
                .i_left_val   (i_sample),
                .i_left_valid (w_left_valid[g]),
                .o_gt         (w_gt[g]),
                .o_val        (w_val[g]),
                .o_valid      (w_valid[g])
            );
        end else begin : g_body
            assign w_left_valid[g] = !i_ctl.fresh && w_valid[g-1];
            psmd_sort_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_sample     (i_sample),
                .i_left_gt    (w_gt[g-1]),
                .i_left_val   (w_val[g-1]),
                .i_left_valid (w_left_valid[g]),
                .o_gt         (w_gt[g]),
                .o_val        (w_val[g]),
                .o_valid      (w_valid[g])
            );
        end
    end

    assign o_rank = w_val[psmd_pkg::RANK_SEL];
    assign o_full = &w_valid;

endmodule

@@ sv/psmd_debounce.sv @@
// Window debounce of one flag: run length of equal flags, saturating at the depth.
// Depends on psmd_pkg.
module psmd_debounce (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_raw,
    output logic o_state
);

    localparam logic [psmd_pkg::RUN_W-1:0] RUN_FULL = psmd_pkg::RUN_W'(psmd_pkg::WINDOW_DEPTH);

    logic                       r_last;
    logic [psmd_pkg::RUN_W-1:0] r_run;
    logic [psmd_pkg::RUN_W-1:0] n_run;
    logic                       r_state;

    always_comb begin
        if (i_raw != r_last) begin
            n_run = psmd_pkg::RUN_W'(1);
        end else if (r_run == RUN_FULL) begin
            n_run = r_run;
        end else begin
            n_run = r_run + psmd_pkg::RUN_W'(1);
        end
    end

    // reset window is all zeros, so a run of zeros is already full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_run   <= RUN_FULL;
            r_state <= 1'b0;
        end else if (i_en) begin
            r_last <= i_raw;
            r_run  <= n_run;
            if (n_run == RUN_FULL) begin
                r_state <= i_raw;
            end
        end
    end

    assign o_state = r_state;

endmodule

@@ sv/power_status_median_debounce_unit.sv @@
// Top level of the power status median debounce unit.
// Depends on psmd_pkg, psmd_rank_chain and psmd_debounce.
//
// Input channel (i_in_valid / o_in_stall): each item carries a mains
// sample, a battery sample and the charger switch level. Each item is sorted
// into a row of 20 cells per channel as it arrives. After the 20th item of a
// round r_eval is set; once the output register is free or not stalled, the
// ranked samples are compared with the thresholds, the debounce run counters
// are updated and one result is loaded into the output register r_out_valid,
// which drives o_out_valid. Throughput is one item per cycle while o_in_stall
// is low, one result per round.
// Output channel (o_out_valid / i_out_stall): a result holds while stalled.
// Items of the next round are still taken; once that round is complete, all
// further items stall until the pending result has been taken.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 mains threshold,
// index 1 battery threshold; always ready.
// Reset: thresholds to their defaults, round counter to zero, debounce windows
// to all zeros with both debounced states clear, no result pending.
module power_status_median_debounce_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_main_sample,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_battery_sample,
    input  logic                          i_charger_switch,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_main_fail,
    output logic                          o_battery_fail,
    output logic                          o_main_raw_fail,
    output logic                          o_battery_raw_fail,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  psmd_pkg::t_cfg_idx            i_cfg_index,
    input  logic [psmd_pkg::SAMPLE_W-1:0] i_cfg_data
);

    localparam logic [psmd_pkg::CNT_W-1:0] CNT_LAST = psmd_pkg::CNT_W'(psmd_pkg::ROUND_SAMPLES - 1);

    logic [psmd_pkg::SAMPLE_W-1:0] r_main_thr;
    logic [psmd_pkg::SAMPLE_W-1:0] r_bat_thr;
    logic [psmd_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_eval;
    logic                          r_sw;
    logic                          r_out_valid;
    logic                          r_main_raw;
    logic                          r_bat_raw;

    psmd_pkg::t_ins_ctl            w_ctl;
    logic                          w_in_acc;
    logic                          w_last;
    logic                          w_eval_go;
    logic                          w_main_raw;
    logic                          w_bat_raw;
    logic [psmd_pkg::SAMPLE_W-1:0] w_main_rank;
    logic [psmd_pkg::SAMPLE_W-1:0] w_bat_rank;
    logic                          w_main_full;
    logic                          w_bat_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_thr <= psmd_pkg::MAIN_THR_RST;
            r_bat_thr  <= psmd_pkg::BAT_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                psmd_pkg::CFG_MAIN_THR: r_main_thr <= i_cfg_data;
                psmd_pkg::CFG_BAT_THR:  r_bat_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eval_go  = r_eval && (!r_out_valid || !i_out_stall);
    assign w_last     = (r_cnt == CNT_LAST);
    assign o_in_stall = r_eval && !w_eval_go;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_ctl.insert = w_in_acc;
    assign w_ctl.fresh  = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_eval <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_cnt <= w_last ? '0 : r_cnt + psmd_pkg::CNT_W'(1);
            end
            if (w_in_acc && w_last) begin
                r_eval <= 1'b1;
            end else if (w_eval_go) begin
                r_eval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_last) begin
            r_sw <= i_charger_switch;
        end
    end

    psmd_rank_chain u_main_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_main_sample),
        .o_rank   (w_main_rank),
        .o_full   (w_main_full)
    );

    psmd_rank_chain u_bat_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (i_battery_sample),
        .o_rank   (w_bat_rank),
        .o_full   (w_bat_full)
    );

    assign w_main_raw = (w_main_rank <= r_main_thr);
    assign w_bat_raw  = !(!r_sw && (w_bat_rank > r_bat_thr));

    psmd_debounce u_main_deb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_eval_go),
        .i_raw   (w_main_raw),
        .o_state (o_main_fail)
    );

    psmd_debounce u_bat_deb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_eval_go),
        .i_raw   (w_bat_raw),
        .o_state (o_battery_fail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_eval_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_go) begin
            r_main_raw <= w_main_raw;
            r_bat_raw  <= w_bat_raw;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_main_raw_fail    = r_main_raw;
    assign o_battery_raw_fail = r_bat_raw;

`ifndef SYNTHESIS
    a_eval_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last) |=> r_eval)
        else $error("round end not followed by evaluation");

    a_chain_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eval |-> (w_main_full && w_bat_full))
        else $error("evaluation with a partly filled sort chain");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_eval_go))
        else $error("result raised without an evaluation");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_eval_go && $past(i_rst_n)) |=> ($stable(o_main_fail) && $stable(o_battery_fail)))
        else $error("debounced state changed outside an evaluation");
`endif

endmodule

@@ test/power_status_median_debounce_unit_tb.sv @@
// Testbench for power_status_median_debounce_unit: rounds of sample items against a
// scoreboard that ranks each round, applies the thresholds and debounces both flags.
// Depends on psmd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module power_status_median_debounce_unit_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic main_fail;
        logic battery_fail;
        logic main_raw_fail;
        logic battery_raw_fail;
    } t_power_status;

    typedef enum logic [1:0] {
        SPREAD_UNIFORM,
        SPREAD_NEAR,
        SPREAD_EXTREME,
        SPREAD_FLAT
    } t_spread;

    class status_scoreboard;
        logic [psmd_pkg::SAMPLE_W-1:0] main_thr;
        logic [psmd_pkg::SAMPLE_W-1:0] bat_thr;
        int unsigned                   round_pos;
        logic [psmd_pkg::SAMPLE_W-1:0] main_round [psmd_pkg::ROUND_SAMPLES];
        logic [psmd_pkg::SAMPLE_W-1:0] bat_round [psmd_pkg::ROUND_SAMPLES];
        int unsigned                   win_pos;
        bit                            main_win [psmd_pkg::WINDOW_DEPTH];
        bit                            bat_win [psmd_pkg::WINDOW_DEPTH];
        bit                            main_stable;
        bit                            bat_stable;
        t_power_status                 due_status [$];
        int unsigned                   mismatches;
        int unsigned                   items_seen;
        int unsigned                   results_seen;
        int unsigned                   main_changes;
        int unsigned                   bat_changes;

        function new();
            main_thr     = psmd_pkg::MAIN_THR_RST;
            bat_thr      = psmd_pkg::BAT_THR_RST;
            round_pos    = 0;
            win_pos      = 0;
            main_stable  = 1'b0;
            bat_stable   = 1'b0;
            mismatches   = 0;
            items_seen   = 0;
            results_seen = 0;
            main_changes = 0;
            bat_changes  = 0;
            foreach (main_win[i]) begin
                main_win[i] = 1'b0;
                bat_win[i]  = 1'b0;
            end
            foreach (main_round[i]) begin
                main_round[i] = '0;
                bat_round[i]  = '0;
            end
        endfunction

        function int unsigned pending();
            return due_status.size();
        endfunction

        function void set_threshold(psmd_pkg::t_cfg_idx idx,
                                    logic [psmd_pkg::SAMPLE_W-1:0] value);
            case (idx)
                psmd_pkg::CFG_MAIN_THR: main_thr = value;
                psmd_pkg::CFG_BAT_THR:  bat_thr  = value;
                default:      ;
            endcase
        endfunction

        function logic [psmd_pkg::SAMPLE_W-1:0] rank_value(
                logic [psmd_pkg::SAMPLE_W-1:0] vals [psmd_pkg::ROUND_SAMPLES]);
            logic [psmd_pkg::SAMPLE_W-1:0] ordered [$];
            foreach (vals[i]) ordered.push_back(vals[i]);
            ordered.sort();
            return ordered[psmd_pkg::RANK_SEL];
        endfunction

        function bit all_agree(bit win [psmd_pkg::WINDOW_DEPTH], bit value);
            foreach (win[i]) begin
                if (win[i] != value) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic [psmd_pkg::SAMPLE_W-1:0] m,
                                logic [psmd_pkg::SAMPLE_W-1:0] b, logic sw);
            logic [psmd_pkg::SAMPLE_W-1:0] m_rank;
            logic [psmd_pkg::SAMPLE_W-1:0] b_rank;
            bit                            m_raw;
            bit                            b_raw;
            t_power_status                 st;
            items_seen++;
            if (round_pos >= psmd_pkg::ROUND_SAMPLES) round_pos = 0;
            main_round[round_pos] = m;
            bat_round[round_pos]  = b;
            round_pos++;
            if (round_pos < psmd_pkg::ROUND_SAMPLES) return;
            round_pos = 0;
            m_rank = rank_value(main_round);
            b_rank = rank_value(bat_round);
            m_raw  = (m_rank <= main_thr);
            b_raw  = !(sw == 1'b0 && b_rank > bat_thr);
            win_pos++;
            if (win_pos >= psmd_pkg::WINDOW_DEPTH) win_pos = 0;
            main_win[win_pos] = m_raw;
            bat_win[win_pos]  = b_raw;
            if (all_agree(main_win, m_raw) && main_stable != m_raw) begin
                main_stable = m_raw;
                main_changes++;
            end
            if (all_agree(bat_win, b_raw) && bat_stable != b_raw) begin
                bat_stable = b_raw;
                bat_changes++;
            end
            st.main_fail        = main_stable;
            st.battery_fail     = bat_stable;
            st.main_raw_fail    = m_raw;
            st.battery_raw_fail = b_raw;
            due_status.push_back(st);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic got, logic want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %b, expected %b",
                                          results_seen, name, got, want));
        endtask

        task check_status(t_power_status got);
            t_power_status want;
            results_seen++;
            if (due_status.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none due", results_seen));
                return;
            end
            want = due_status.pop_front();
            check_field("main_fail", got.main_fail, want.main_fail);
            check_field("battery_fail", got.battery_fail, want.battery_fail);
            check_field("main_raw_fail", got.main_raw_fail, want.main_raw_fail);
            check_field("battery_raw_fail", got.battery_raw_fail, want.battery_raw_fail);
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [psmd_pkg::SAMPLE_W-1:0] i_main_sample;
    logic [psmd_pkg::SAMPLE_W-1:0] i_battery_sample;
    logic                          i_charger_switch;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_main_fail;
    logic                          o_battery_fail;
    logic                          o_main_raw_fail;
    logic                          o_battery_raw_fail;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    psmd_pkg::t_cfg_idx            i_cfg_index;
    logic [psmd_pkg::SAMPLE_W-1:0] i_cfg_data;

    status_scoreboard sb = new();

    bit          idle_off;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned cfg_writes;

    power_status_median_debounce_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_main_sample      (i_main_sample),
        .i_battery_sample   (i_battery_sample),
        .i_charger_switch   (i_charger_switch),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_main_fail        (o_main_fail),
        .o_battery_fail     (o_battery_fail),
        .o_main_raw_fail    (o_main_raw_fail),
        .o_battery_raw_fail (o_battery_raw_fail),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_item(i_main_sample, i_battery_sample, i_charger_switch);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_status({o_main_fail, o_battery_fail, o_main_raw_fail, o_battery_raw_fail});
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !idle_off && ($urandom_range(0, 99) < 31);
            end
        end
    end

    function automatic logic [psmd_pkg::SAMPLE_W-1:0] pick_centre(
            logic [psmd_pkg::SAMPLE_W-1:0] thr);
        case ($urandom_range(0, 2))
            0:       return thr;
            1:       return (thr == '1) ? thr : thr + 1'b1;
            default: return psmd_pkg::SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [psmd_pkg::SAMPLE_W-1:0] pick_sample(
            t_spread s, logic [psmd_pkg::SAMPLE_W-1:0] centre);
        int v;
        case (s)
            SPREAD_UNIFORM: return psmd_pkg::SAMPLE_W'($urandom_range(0, 4095));
            SPREAD_NEAR: begin
                v = int'(centre) + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return psmd_pkg::SAMPLE_W'(v);
            end
            SPREAD_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 12'd0;
                    1:       return 12'd1;
                    2:       return 12'd4094;
                    default: return 12'd4095;
                endcase
            end
            default: return centre;
        endcase
    endfunction

    task automatic send_item(logic [psmd_pkg::SAMPLE_W-1:0] m,
                             logic [psmd_pkg::SAMPLE_W-1:0] b, logic sw);
        while (!idle_off && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_main_sample    <= m;
        i_battery_sample <= b;
        i_charger_switch <= sw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // rank lands exactly on the mains threshold and one above the battery one
    task automatic send_directed();
        int unsigned                   k;
        logic [psmd_pkg::SAMPLE_W-1:0] m;
        logic [psmd_pkg::SAMPLE_W-1:0] b;
        for (int i = 0; i < psmd_pkg::ROUND_SAMPLES; i++) begin
            k = psmd_pkg::ROUND_SAMPLES - 1 - i;
            if (k < psmd_pkg::RANK_SEL) begin
                m = psmd_pkg::SAMPLE_W'(k);
                b = '0;
            end else if (k == psmd_pkg::RANK_SEL) begin
                m = psmd_pkg::MAIN_THR_RST;
                b = psmd_pkg::BAT_THR_RST + 1'b1;
            end else begin
                m = '1;
                b = psmd_pkg::SAMPLE_W'(4095 - (k - psmd_pkg::RANK_SEL - 1));
            end
            send_item(m, b, (k == 0) ? 1'b0 : logic'(k % 2));
        end
    endtask

    task automatic send_rounds(int unsigned rounds);
        t_spread                       ms;
        t_spread                       bs;
        logic [psmd_pkg::SAMPLE_W-1:0] mc;
        logic [psmd_pkg::SAMPLE_W-1:0] bc;
        repeat (rounds) begin
            ms = t_spread'($urandom_range(0, 3));
            bs = t_spread'($urandom_range(0, 3));
            mc = pick_centre(sb.main_thr);
            bc = pick_centre(sb.bat_thr);
            for (int i = 0; i < psmd_pkg::ROUND_SAMPLES; i++)
                send_item(pick_sample(ms, mc), pick_sample(bs, bc), logic'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
    endtask

    task automatic write_threshold(psmd_pkg::t_cfg_idx idx,
                                   logic [psmd_pkg::SAMPLE_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_threshold(idx, value);
        cfg_writes++;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_main_sample    <= '0;
        i_battery_sample <= '0;
        i_charger_switch <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= psmd_pkg::CFG_MAIN_THR;
        i_cfg_data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        send_rounds(4);

        // back-pressure: the receiver holds off while rounds keep coming
        hold_requests++;
        send_rounds(3);
        wait_drained();

        // both flags forced high long enough to fill the debounce windows
        write_threshold(psmd_pkg::CFG_MAIN_THR, '1);
        write_threshold(psmd_pkg::CFG_BAT_THR, '1);
        idle_off = 1'b1;
        send_rounds(24);
        idle_off = 1'b0;
        send_rounds(48);

        write_threshold(psmd_pkg::CFG_MAIN_THR, '0);
        write_threshold(psmd_pkg::CFG_BAT_THR, '0);
        send_rounds(2);

        repeat (2) begin
            write_threshold(psmd_pkg::CFG_MAIN_THR,
                            psmd_pkg::SAMPLE_W'($urandom_range(0, 4095)));
            write_threshold(psmd_pkg::CFG_BAT_THR,
                            psmd_pkg::SAMPLE_W'($urandom_range(0, 4095)));
            send_rounds(3);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("Run covered %0d items, %0d results and %0d threshold writes",
                 sb.items_seen, sb.results_seen, cfg_writes);
        $display("Debounced changes: mains %0d, battery %0d; one %0d-cycle receiver hold-off",
                 sb.main_changes, sb.bat_changes, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
